FILE: sv/cpualu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cpualu_pkg;

  // Operation codes.
  localparam logic [5:0] CMD_ADD    = 6'd0;
  localparam logic [5:0] CMD_ADC    = 6'd1;
  localparam logic [5:0] CMD_SUB    = 6'd2;
  localparam logic [5:0] CMD_SBC    = 6'd3;
  localparam logic [5:0] CMD_AND    = 6'd4;
  localparam logic [5:0] CMD_XOR    = 6'd5;
  localparam logic [5:0] CMD_OR     = 6'd6;
  localparam logic [5:0] CMD_CP     = 6'd7;
  localparam logic [5:0] CMD_INC    = 6'd8;
  localparam logic [5:0] CMD_DEC    = 6'd9;
  localparam logic [5:0] CMD_RLCA   = 6'd10;
  localparam logic [5:0] CMD_RRCA   = 6'd11;
  localparam logic [5:0] CMD_RLA    = 6'd12;
  localparam logic [5:0] CMD_RRA    = 6'd13;
  localparam logic [5:0] CMD_DAA    = 6'd14;
  localparam logic [5:0] CMD_CPL    = 6'd15;
  localparam logic [5:0] CMD_SCF    = 6'd16;
  localparam logic [5:0] CMD_CCF    = 6'd17;
  localparam logic [5:0] CMD_RLC    = 6'd18;
  localparam logic [5:0] CMD_RRC    = 6'd19;
  localparam logic [5:0] CMD_RL     = 6'd20;
  localparam logic [5:0] CMD_RR     = 6'd21;
  localparam logic [5:0] CMD_SLA    = 6'd22;
  localparam logic [5:0] CMD_SRA    = 6'd23;
  localparam logic [5:0] CMD_SWAP   = 6'd24;
  localparam logic [5:0] CMD_SRL    = 6'd25;
  localparam logic [5:0] CMD_BIT    = 6'd26;
  localparam logic [5:0] CMD_RES    = 6'd27;
  localparam logic [5:0] CMD_SET    = 6'd28;
  localparam logic [5:0] CMD_ADD16  = 6'd29;
  localparam logic [5:0] CMD_ADDSP  = 6'd30;
  localparam logic [5:0] CMD_INC16  = 6'd31;
  localparam logic [5:0] CMD_DEC16  = 6'd32;

  // Decimal adjust constants.
  localparam logic [7:0] DAA_LIMIT  = 8'h99;
  localparam logic [7:0] DAA_HI     = 8'h60;
  localparam logic [7:0] DAA_LO     = 8'h06;
  localparam logic [3:0] DAA_DIGIT  = 4'd9;

  // Flag bit positions.
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  typedef struct packed {
    logic [5:0]  command;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic [3:0]  flags_in;
  } in_t;

  typedef struct packed {
    logic [15:0] result;
    logic [3:0]  flags_out;
  } out_t;

  // Decode stage record: adder operands prepared.
  typedef struct packed {
    logic [5:0]  command;
    logic [15:0] x;
    logic [15:0] y;
    logic        cin;
    logic [7:0]  a8;
    logic [7:0]  b8;
    logic [2:0]  bit_index;
    logic [3:0]  flags;
    logic        daa_c;
  } dec_t;

  // Execute stage record: raw sum with carry taps and the bitwise result.
  typedef struct packed {
    logic [5:0]  command;
    logic [15:0] sum;
    logic        c3;
    logic        c7;
    logic        c11;
    logic        c15;
    logic [7:0]  alt;
    logic        sc;
    logic        bit_z;
    logic [3:0]  flags;
    logic        daa_c;
  } exe_t;

endpackage

`default_nettype wire

FILE: sv/cpu_alu_with_flags.sv
// Flag-producing ALU of an 8-bit handheld CPU as a three-stage pipeline.
// Every item carries an operation code, two 16-bit operands, a bit index and
// the incoming Z/N/H/C flags, and yields one item with the result and the new
// flags. The block takes one item per cycle while no stage is held by back
// pressure; each item passes in order through the three register stages
// (operand preparation, the shared 16-bit adder with bitwise unit, and the
// flag and result select that ends in the output register). Each stage holds
// its own valid bit, and its ready is high when the stage is empty or its
// item moves on, so back pressure stalls the pipeline without losing,
// repeating or reordering items. 8-bit operations return their result in the
// low byte with the upper byte zero; flags an operation does not define pass
// through unchanged; unused codes return zero with the flags unchanged.
`timescale 1ns / 1ps
`default_nettype none

module cpu_alu_with_flags
  import cpualu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // Between decode and execute.
  logic dec_valid;
  logic dec_ready;
  dec_t dec_data;

  // Between execute and the flag stage.
  logic exe_valid;
  logic exe_ready;
  exe_t exe_data;

  // Stage one: turns every arithmetic operation into an add on one adder
  // and works out the decimal adjust correction and its carry.
  cpualu_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .dn_valid (dec_valid),
    .dn_ready (dec_ready),
    .dn_data  (dec_data)
  );

  // Stage two: the 16-bit sum with its nibble and byte carries, plus the
  // logic, shift, rotate and bit operations on the low byte.
  cpualu_exec u_exec (
    .clk      (clk),
    .rst      (rst),
    .up_valid (dec_valid),
    .up_ready (dec_ready),
    .up_data  (dec_data),
    .dn_valid (exe_valid),
    .dn_ready (exe_ready),
    .dn_data  (exe_data)
  );

  // Stage three: zero detect, flag assembly and result select into the
  // output register.
  cpualu_flags u_flags (
    .clk      (clk),
    .rst      (rst),
    .up_valid (exe_valid),
    .up_ready (exe_ready),
    .up_data  (exe_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (out_data)
  );

`ifndef SYNTHESIS
  // A consumer that takes every item never stalls the input side.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while the output side is ready");

  // With the output ready throughout, an accepted item reaches the output.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && out_ready) ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("accepted item did not reach the output in three cycles");

  // Byte operations keep the upper adder inputs at zero, so carries stay 8-bit.
  a_byte_ops: assert property (@(posedge clk) disable iff (rst)
    (dec_valid && (dec_data.command < CMD_ADD16))
      |-> (dec_data.x[15:8] == 8'h00) && (dec_data.y[15:8] == 8'h00))
    else $error("byte operation drove the upper adder byte");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

`default_nettype wire

FILE: sv/cpualu_decode.sv
`timescale 1ns / 1ps
`default_nettype none

module cpualu_decode
  import cpualu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  output logic up_ready,
  input  in_t  up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output dec_t dn_data
);

  logic [7:0] a;
  logic [7:0] b;
  logic [7:0] corr;
  logic       fn;
  logic       fh;
  logic       fc;
  dec_t       rec;
  logic       load;

  assign a    = up_data.operand_a[7:0];
  assign b    = up_data.operand_b[7:0];
  assign fn   = up_data.flags_in[FLAG_N];
  assign fh   = up_data.flags_in[FLAG_H];
  assign fc   = up_data.flags_in[FLAG_C];

  assign up_ready = !dn_valid || dn_ready;
  assign load     = up_valid && up_ready;

  // Subtraction runs as x + ~y + !borrow so that one adder serves every arithmetic op.
  always_comb begin
    corr          = 8'h00;
    rec.command   = up_data.command;
    rec.x         = {8'h00, a};
    rec.y         = 16'h0000;
    rec.cin       = 1'b0;
    rec.a8        = a;
    rec.b8        = b;
    rec.bit_index = up_data.bit_index;
    rec.flags     = up_data.flags_in;
    rec.daa_c     = fc;
    unique case (up_data.command)
      CMD_ADD: rec.y = {8'h00, b};
      CMD_ADC: begin
        rec.y   = {8'h00, b};
        rec.cin = fc;
      end
      CMD_SUB, CMD_CP: begin
        rec.y   = {8'h00, ~b};
        rec.cin = 1'b1;
      end
      CMD_SBC: begin
        rec.y   = {8'h00, ~b};
        rec.cin = !fc;
      end
      CMD_INC: rec.cin = 1'b1;
      CMD_DEC: rec.y = 16'h00FF;
      CMD_DAA: begin
        if (!fn) begin
          if (fc || (a > DAA_LIMIT)) begin
            corr      = corr | DAA_HI;
            rec.daa_c = 1'b1;
          end
          if (fh || (a[3:0] > DAA_DIGIT)) corr = corr | DAA_LO;
          rec.y = {8'h00, corr};
        end else begin
          if (fh) corr = corr | DAA_LO;
          if (fc) corr = corr | DAA_HI;
          rec.y   = {8'h00, ~corr};
          rec.cin = 1'b1;
        end
      end
      CMD_ADD16: begin
        rec.x = up_data.operand_a;
        rec.y = up_data.operand_b;
      end
      CMD_ADDSP: begin
        rec.x = up_data.operand_a;
        rec.y = {{8{b[7]}}, b};
      end
      CMD_INC16: begin
        rec.x   = up_data.operand_a;
        rec.cin = 1'b1;
      end
      CMD_DEC16: begin
        rec.x = up_data.operand_a;
        rec.y = 16'hFFFF;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dn_data <= rec;
    end
  end

endmodule

`default_nettype wire

FILE: sv/cpualu_exec.sv
`timescale 1ns / 1ps
`default_nettype none

module cpualu_exec
  import cpualu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  output logic up_ready,
  input  dec_t up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output exe_t dn_data
);

  logic [16:0] total;
  logic [7:0]  a;
  logic [7:0]  b;
  logic [7:0]  mask;
  logic        fc;
  exe_t        rec;
  logic        load;

  assign a    = up_data.a8;
  assign b    = up_data.b8;
  assign fc   = up_data.flags[FLAG_C];
  assign mask = 8'd1 << up_data.bit_index;

  assign total = {1'b0, up_data.x} + {1'b0, up_data.y} + {16'h0000, up_data.cin};

  assign up_ready = !dn_valid || dn_ready;
  assign load     = up_valid && up_ready;

  always_comb begin
    rec.command = up_data.command;
    rec.sum     = total[15:0];
    // Carry into bit k+1 recovered from the sum bit and the operand bits.
    rec.c3      = up_data.x[4] ^ up_data.y[4] ^ total[4];
    rec.c7      = up_data.x[8] ^ up_data.y[8] ^ total[8];
    rec.c11     = up_data.x[12] ^ up_data.y[12] ^ total[12];
    rec.c15     = total[16];
    rec.flags   = up_data.flags;
    rec.daa_c   = up_data.daa_c;
    rec.bit_z   = !a[up_data.bit_index];
    rec.alt     = a;
    rec.sc      = 1'b0;
    unique case (up_data.command)
      CMD_AND:  rec.alt = a & b;
      CMD_XOR:  rec.alt = a ^ b;
      CMD_OR:   rec.alt = a | b;
      CMD_CPL:  rec.alt = ~a;
      CMD_RLCA, CMD_RLC: begin
        rec.alt = {a[6:0], a[7]};
        rec.sc  = a[7];
      end
      CMD_RRCA, CMD_RRC: begin
        rec.alt = {a[0], a[7:1]};
        rec.sc  = a[0];
      end
      CMD_RLA, CMD_RL: begin
        rec.alt = {a[6:0], fc};
        rec.sc  = a[7];
      end
      CMD_RRA, CMD_RR: begin
        rec.alt = {fc, a[7:1]};
        rec.sc  = a[0];
      end
      CMD_SLA: begin
        rec.alt = {a[6:0], 1'b0};
        rec.sc  = a[7];
      end
      CMD_SRA: begin
        rec.alt = {a[7], a[7:1]};
        rec.sc  = a[0];
      end
      CMD_SRL: begin
        rec.alt = {1'b0, a[7:1]};
        rec.sc  = a[0];
      end
      CMD_SWAP: rec.alt = {a[3:0], a[7:4]};
      CMD_RES:  rec.alt = a & ~mask;
      CMD_SET:  rec.alt = a | mask;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dn_data <= rec;
    end
  end

endmodule

`default_nettype wire

FILE: sv/cpualu_flags.sv
`timescale 1ns / 1ps
`default_nettype none

module cpualu_flags
  import cpualu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic up_valid,
  output logic up_ready,
  input  exe_t up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output out_t dn_data
);

  logic       zs;
  logic       za;
  logic       fz;
  logic       fn;
  logic       fc;
  logic [7:0] s8;
  out_t       rec;
  logic       load;

  assign s8 = up_data.sum[7:0];
  assign zs = (s8 == 8'h00);
  assign za = (up_data.alt == 8'h00);
  assign fz = up_data.flags[FLAG_Z];
  assign fn = up_data.flags[FLAG_N];
  assign fc = up_data.flags[FLAG_C];

  assign up_ready = !dn_valid || dn_ready;
  assign load     = up_valid && up_ready;

  always_comb begin
    rec.result    = {8'h00, up_data.alt};
    rec.flags_out = up_data.flags;
    unique case (up_data.command)
      CMD_ADD, CMD_ADC: begin
        rec.result    = {8'h00, s8};
        rec.flags_out = {zs, 1'b0, up_data.c3, up_data.c7};
      end
      CMD_SUB, CMD_SBC: begin
        rec.result    = {8'h00, s8};
        rec.flags_out = {zs, 1'b1, !up_data.c3, !up_data.c7};
      end
      CMD_CP:  rec.flags_out = {zs, 1'b1, !up_data.c3, !up_data.c7};
      CMD_INC: begin
        rec.result    = {8'h00, s8};
        rec.flags_out = {zs, 1'b0, up_data.c3, fc};
      end
      CMD_DEC: begin
        rec.result    = {8'h00, s8};
        rec.flags_out = {zs, 1'b1, !up_data.c3, fc};
      end
      CMD_AND: rec.flags_out = {za, 1'b0, 1'b1, 1'b0};
      CMD_XOR, CMD_OR, CMD_SWAP: rec.flags_out = {za, 3'b000};
      CMD_RLCA, CMD_RRCA, CMD_RLA, CMD_RRA:
        rec.flags_out = {3'b000, up_data.sc};
      CMD_RLC, CMD_RRC, CMD_RL, CMD_RR, CMD_SLA, CMD_SRA, CMD_SRL:
        rec.flags_out = {za, 2'b00, up_data.sc};
      CMD_DAA: begin
        rec.result    = {8'h00, s8};
        rec.flags_out = {zs, fn, 1'b0, up_data.daa_c};
      end
      CMD_CPL: rec.flags_out = {fz, 1'b1, 1'b1, fc};
      CMD_SCF: rec.flags_out = {fz, 1'b0, 1'b0, 1'b1};
      CMD_CCF: rec.flags_out = {fz, 1'b0, 1'b0, !fc};
      CMD_BIT: rec.flags_out = {up_data.bit_z, 1'b0, 1'b1, fc};
      CMD_RES, CMD_SET: ;
      CMD_ADD16: begin
        rec.result    = up_data.sum;
        rec.flags_out = {fz, 1'b0, up_data.c11, up_data.c15};
      end
      CMD_ADDSP: begin
        rec.result    = up_data.sum;
        rec.flags_out = {2'b00, up_data.c3, up_data.c7};
      end
      CMD_INC16, CMD_DEC16: rec.result = up_data.sum;
      default: rec.result = 16'h0000;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dn_data <= rec;
    end
  end

endmodule

`default_nettype wire

FILE: sim/cpu_alu_with_flags_tb.sv
`timescale 1ns / 1ps

module cpu_alu_with_flags_tb
  import cpualu_pkg::*;
;

  // The first and last operation codes that the ALU leaves undefined.
  localparam logic [5:0] CMD_FIRST_UNUSED = CMD_DEC16 + 6'd1;
  localparam logic [5:0] CMD_LAST_UNUSED  = 6'd63;

  localparam int RANDOM_ITEMS = 1000;
  // The length of the one long output hold-off. It is far longer than the pipeline
  // is deep, so the block must fill up and drop in_ready.
  localparam int LONG_HOLD    = 120;

  // These are the ways the receiver paces out_ready within one segment.
  typedef enum int unsigned {RX_FREE, RX_HALF, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  // This tracker predicts each result and holds the predictions in order.
  // The ALU keeps no state, so every prediction depends only on its own item.
  class alu_scoreboard;
    out_t        expected_results[$];
    int unsigned items_in;
    int unsigned results_checked;
    int unsigned errors;
    bit [63:0]   codes_seen;

    function logic [3:0] make_flags(logic z, logic n, logic h, logic c);
      logic [3:0] f;
      f[FLAG_Z] = z;
      f[FLAG_N] = n;
      f[FLAG_H] = h;
      f[FLAG_C] = c;
      return f;
    endfunction

    function out_t predict_alu(in_t item);
      logic [7:0]  a, b, r8;
      logic [15:0] a16, b16, r16;
      logic [3:0]  f;
      logic        zk, nk, hk, ck, tc, dc, wide;
      logic [4:0]  h5;
      logic [8:0]  s9;
      logic [12:0] h13;
      logic [16:0] s17;
      out_t        o;
      a16  = item.operand_a;
      b16  = item.operand_b;
      a    = a16[7:0];
      b    = b16[7:0];
      f    = item.flags_in;
      zk   = f[FLAG_Z];
      nk   = f[FLAG_N];
      hk   = f[FLAG_H];
      ck   = f[FLAG_C];
      r8   = 8'h00;
      r16  = 16'h0000;
      wide = 1'b0;
      case (item.command)
        CMD_ADD, CMD_ADC: begin
          tc = (item.command == CMD_ADC) ? ck : 1'b0;
          s9 = {1'b0, a} + {1'b0, b} + {8'h00, tc};
          h5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, tc};
          r8 = s9[7:0];
          f  = make_flags(r8 == 8'h00, 1'b0, h5[4], s9[8]);
        end
        CMD_SUB, CMD_SBC, CMD_CP: begin
          // Both differences are wide enough that their sign bit is the borrow.
          tc = (item.command == CMD_SBC) ? ck : 1'b0;
          s9 = {1'b0, a} - {1'b0, b} - {8'h00, tc};
          h5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, tc};
          r8 = s9[7:0];
          f  = make_flags(r8 == 8'h00, 1'b1, h5[4], s9[8]);
          if (item.command == CMD_CP) r8 = a;
        end
        CMD_AND: begin
          r8 = a & b;
          f  = make_flags(r8 == 8'h00, 1'b0, 1'b1, 1'b0);
        end
        CMD_XOR: begin
          r8 = a ^ b;
          f  = make_flags(r8 == 8'h00, 1'b0, 1'b0, 1'b0);
        end
        CMD_OR: begin
          r8 = a | b;
          f  = make_flags(r8 == 8'h00, 1'b0, 1'b0, 1'b0);
        end
        CMD_INC: begin
          r8 = a + 8'h01;
          f  = make_flags(r8 == 8'h00, 1'b0, a[3:0] == 4'hF, ck);
        end
        CMD_DEC: begin
          r8 = a - 8'h01;
          f  = make_flags(r8 == 8'h00, 1'b1, a[3:0] == 4'h0, ck);
        end
        // The accumulator rotates always clear Z. The CB-prefixed forms set it from
        // the result.
        CMD_RLCA, CMD_RLC: begin
          r8 = {a[6:0], a[7]};
          f  = make_flags(item.command == CMD_RLC && r8 == 8'h00, 1'b0, 1'b0, a[7]);
        end
        CMD_RRCA, CMD_RRC: begin
          r8 = {a[0], a[7:1]};
          f  = make_flags(item.command == CMD_RRC && r8 == 8'h00, 1'b0, 1'b0, a[0]);
        end
        CMD_RLA, CMD_RL: begin
          r8 = {a[6:0], ck};
          f  = make_flags(item.command == CMD_RL && r8 == 8'h00, 1'b0, 1'b0, a[7]);
        end
        CMD_RRA, CMD_RR: begin
          r8 = {ck, a[7:1]};
          f  = make_flags(item.command == CMD_RR && r8 == 8'h00, 1'b0, 1'b0, a[0]);
        end
        CMD_DAA: begin
          // After an addition, both corrections are tested on the original value.
          // After a subtraction, C stays as it was.
          dc = ck;
          r8 = a;
          if (!nk) begin
            if (ck || a > DAA_LIMIT) begin
              r8 = r8 + DAA_HI;
              dc = 1'b1;
            end
            if (hk || a[3:0] > DAA_DIGIT) r8 = r8 + DAA_LO;
          end else begin
            if (hk) r8 = r8 - DAA_LO;
            if (ck) r8 = r8 - DAA_HI;
          end
          f = make_flags(r8 == 8'h00, nk, 1'b0, dc);
        end
        CMD_CPL: begin
          r8 = ~a;
          f  = make_flags(zk, 1'b1, 1'b1, ck);
        end
        CMD_SCF: begin
          r8 = a;
          f  = make_flags(zk, 1'b0, 1'b0, 1'b1);
        end
        CMD_CCF: begin
          r8 = a;
          f  = make_flags(zk, 1'b0, 1'b0, ~ck);
        end
        CMD_SLA: begin
          r8 = {a[6:0], 1'b0};
          f  = make_flags(r8 == 8'h00, 1'b0, 1'b0, a[7]);
        end
        CMD_SRA: begin
          r8 = {a[7], a[7:1]};
          f  = make_flags(r8 == 8'h00, 1'b0, 1'b0, a[0]);
        end
        CMD_SWAP: begin
          r8 = {a[3:0], a[7:4]};
          f  = make_flags(r8 == 8'h00, 1'b0, 1'b0, 1'b0);
        end
        CMD_SRL: begin
          r8 = {1'b0, a[7:1]};
          f  = make_flags(r8 == 8'h00, 1'b0, 1'b0, a[0]);
        end
        CMD_BIT: begin
          r8 = a;
          f  = make_flags(a[item.bit_index] == 1'b0, 1'b0, 1'b1, ck);
        end
        CMD_RES: r8 = a & ~(8'h01 << item.bit_index);
        CMD_SET: r8 = a | (8'h01 << item.bit_index);
        CMD_ADD16: begin
          wide = 1'b1;
          s17  = {1'b0, a16} + {1'b0, b16};
          h13  = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
          r16  = s17[15:0];
          f    = make_flags(zk, 1'b0, h13[12], s17[16]);
        end
        CMD_ADDSP: begin
          // The sum uses the sign-extended offset. The flags come from an unsigned
          // byte add.
          wide = 1'b1;
          r16  = a16 + {{8{b[7]}}, b};
          h5   = {1'b0, a16[3:0]} + {1'b0, b[3:0]};
          s9   = {1'b0, a16[7:0]} + {1'b0, b};
          f    = make_flags(1'b0, 1'b0, h5[4], s9[8]);
        end
        CMD_INC16: begin
          wide = 1'b1;
          r16  = a16 + 16'h0001;
        end
        CMD_DEC16: begin
          wide = 1'b1;
          r16  = a16 - 16'h0001;
        end
        default: begin
          wide = 1'b1;
          r16  = 16'h0000;
        end
      endcase
      o.result    = wide ? r16 : {8'h00, r8};
      o.flags_out = f;
      return o;
    endfunction

    function void note_input(in_t item);
      expected_results.push_back(predict_alu(item));
      codes_seen[item.command] = 1'b1;
      items_in++;
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual result=%h flags=%b",
                 $time, got.result, got.flags_out);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      results_checked++;
      if (got.result !== want.result) begin
        $display("%0t: result mismatch, expected %h, actual %h",
                 $time, want.result, got.result);
        errors++;
      end
      if (got.flags_out !== want.flags_out) begin
        $display("%0t: flags mismatch, expected %b, actual %b",
                 $time, want.flags_out, got.flags_out);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function int unsigned defined_codes_seen();
      int unsigned n;
      n = 0;
      for (int k = CMD_ADD; k <= CMD_DEC16; k++) n += codes_seen[k];
      return n;
    endfunction
  endclass

  logic clk;
  logic rst       = 1'b1;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  alu_scoreboard sb;
  int unsigned   burst_left;
  int unsigned   input_stalls;

  cpu_alu_with_flags DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // This is a hard stop for a hung handshake. A correct run finishes in a small
  // fraction of this time, even with every stall the receiver can apply.
  initial begin
    #400_000;
    $display("FAILURE");
    $finish;
  end

  // The monitor samples both channels at the rising edge. The driver changes its
  // inputs only through nonblocking assignments, so the values read here are the
  // ones that were present at the edge. The input is noted before the output is
  // checked, so a result can never overtake its own prediction.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_input(in_data);
      if (in_valid && !in_ready) input_stalls++;
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  function automatic in_t make_item(logic [5:0] cmd, logic [15:0] a, logic [15:0] b,
                                    logic [2:0] bi, logic [3:0] f);
    in_t item;
    item.command   = cmd;
    item.operand_a = a;
    item.operand_b = b;
    item.bit_index = bi;
    item.flags_in  = f;
    return item;
  endfunction

  // Operand values lean toward the edges where carries and borrows flip.
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h00FF;
      3:       return 16'h8000 | 16'($urandom_range(0, 255));
      4:       return 16'h0FF0 + 16'($urandom_range(0, 31));
      5:       return 16'($urandom_range(0, 255));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic in_t random_item();
    logic [5:0] cmd;
    // Most items use a defined operation. About one in ten uses an unused code,
    // which must return zero and leave the flags as they were.
    if ($urandom_range(0, 9) == 0) cmd = 6'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_UNUSED));
    else cmd = 6'($urandom_range(CMD_ADD, CMD_DEC16));
    return make_item(cmd, pick_operand(), pick_operand(), 3'($urandom_range(0, 7)),
                     4'($urandom_range(0, 15)));
  endfunction

  // This task offers one item and returns at the edge where it is accepted. Valid
  // stays high into the next call, so bursts go through back to back.
  task automatic send_item(input in_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // At the end of a burst, the sender may drop valid for a random gap. Some
  // bursts run straight into the next one, with no gap at all.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // The receiver works in segments, and each segment has its own pacing. The
  // fourth segment is one long hold-off. The sender keeps offering items during it,
  // so the pipeline fills and drops in_ready.
  initial begin : receiver
    int unsigned seg_len;
    int unsigned seg;
    rx_mode_e    mode;
    seg = 0;
    wait (rst == 1'b0);
    forever begin
      if (seg == 3) begin
        repeat (LONG_HOLD) begin
          @(posedge clk);
          out_ready <= 1'b0;
        end
      end else begin
        seg_len = $urandom_range(8, 60);
        mode    = rx_mode_e'($urandom_range(RX_FREE, RX_TOGGLE));
        repeat (seg_len) begin
          @(posedge clk);
          case (mode)
            RX_FREE:   out_ready <= 1'b1;
            RX_HALF:   out_ready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
            default:   out_ready <= ~out_ready;
          endcase
        end
      end
      seg++;
    end
  end

  initial begin : stimulus
    int k;
    sb           = new();
    input_stalls = 0;
    burst_left   = $urandom_range(1, 24);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // First, every defined operation is sent once. The operands rotate through
    // all-ones, all-zeros and the sign and nibble edges. The bit index and the
    // flags step with the code, so every flag value is seen across the sweep.
    for (k = CMD_ADD; k <= CMD_DEC16; k++) begin
      case (k % 4)
        0:       send_item(make_item(6'(k), 16'hFFFF, 16'h0001, 3'(k), 4'(k)));
        1:       send_item(make_item(6'(k), 16'h0000, 16'hFFFF, 3'(k), 4'(k)));
        2:       send_item(make_item(6'(k), 16'h8001, 16'h00FF, 3'(k), 4'(k)));
        default: send_item(make_item(6'(k), 16'h0F0F, 16'h8080, 3'(k), 4'(k)));
      endcase
      pace_sender();
    end

    // Next come the special cases named in the operation list. Decimal adjust
    // is tested after an addition that needs both corrections, and after a
    // subtraction with both half carry and carry set.
    send_item(make_item(CMD_DAA, 16'h009A, 16'h0000, 3'd0, 4'b0000));
    send_item(make_item(CMD_DAA, 16'h0000, 16'h0000, 3'd0, 4'b0111));
    // The 16-bit add is tested with a carry out of bit 11 and with one out of bit 15.
    send_item(make_item(CMD_ADD16, 16'h0FFF, 16'h0001, 3'd0, 4'b1000));
    send_item(make_item(CMD_ADD16, 16'hFFFF, 16'h0001, 3'd0, 4'b0000));
    // Stack pointer plus a negative offset should set both half carry and carry.
    send_item(make_item(CMD_ADDSP, 16'h00FF, 16'h00FF, 3'd0, 4'b1100));
    // The 16-bit increment and decrement should both wrap around.
    send_item(make_item(CMD_INC16, 16'hFFFF, 16'h0000, 3'd0, 4'b1111));
    send_item(make_item(CMD_DEC16, 16'h0000, 16'h0000, 3'd0, 4'b0000));
    // A bit test on the top bit should see a clear bit.
    send_item(make_item(CMD_BIT, 16'h007F, 16'h0000, 3'd7, 4'b0001));
    // The first and last unused codes should both return zero.
    send_item(make_item(CMD_FIRST_UNUSED, 16'hFFFF, 16'hFFFF, 3'd7, 4'b1010));
    send_item(make_item(CMD_LAST_UNUSED, 16'hFFFF, 16'hFFFF, 3'd7, 4'b0101));
    pace_sender();

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      send_item(random_item());
      pace_sender();
    end
    in_valid <= 1'b0;

    // The watchdog bounds this wait. The extra cycles afterward would catch any
    // result that the block sends without an item behind it.
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d items covering %0d of 33 defined operations plus unused codes;",
             sb.items_in, sb.defined_codes_seen());
    $display("checked %0d results, with the input stalled for %0d cycles by back pressure.",
             sb.results_checked, input_stalls);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: cpu_alu_with_flags.f
sv/cpualu_pkg.sv
sv/cpualu_decode.sv
sv/cpualu_exec.sv
sv/cpualu_flags.sv
sv/cpu_alu_with_flags.sv
sim/cpu_alu_with_flags_tb.sv
